FILE: hdl/vcs_pkg.sv
// Shared constants, types and the arctangent table of the velocity command shaper.
package vcs_pkg;

    localparam int VEL_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET_X = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET_Y = 1'b1;

    localparam int ACC_WIDTH    = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_WIDTH   = $clog2(CORDIC_STEPS);

    localparam logic [ACC_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ACC_WIDTH-1:0] HALF_TURN    = 32'h8000_0000;

    localparam int COEF_WIDTH = 17;
    localparam logic signed [COEF_WIDTH-1:0] CORDIC_GAIN     = 17'sd39797;
    localparam logic signed [COEF_WIDTH-1:0] CORDIC_GAIN_NEG = -17'sd39797;
    localparam logic signed [COEF_WIDTH-1:0] W_XY_NEW        = 17'sd19661;
    localparam logic signed [COEF_WIDTH-1:0] W_TURN_NEW      = 17'sd39322;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                 rotate;
        logic                 flip;
        logic [ACC_WIDTH-1:0] angle;
    } cls_t;

    function automatic logic [ACC_WIDTH-1:0] atan_entry(input logic [STEP_WIDTH-1:0] i);
        logic [ACC_WIDTH-1:0] r;
        unique case (i)
            4'd0:    r = 32'd536870912;
            4'd1:    r = 32'd316933406;
            4'd2:    r = 32'd167458907;
            4'd3:    r = 32'd85004756;
            4'd4:    r = 32'd42667331;
            4'd5:    r = 32'd21354465;
            4'd6:    r = 32'd10679838;
            4'd7:    r = 32'd5340245;
            4'd8:    r = 32'd2670163;
            4'd9:    r = 32'd1335087;
            4'd10:   r = 32'd667544;
            4'd11:   r = 32'd333772;
            4'd12:   r = 32'd166886;
            4'd13:   r = 32'd83443;
            4'd14:   r = 32'd41722;
            4'd15:   r = 32'd20861;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/vcs_front.sv
// Request intake: heading classification and a short request queue.
module vcs_front
    import vcs_pkg::*;
#(
    parameter int VEL_WIDTH   = VEL_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VEL_WIDTH-1:0]   vel_x,
    input  logic signed [VEL_WIDTH-1:0]   vel_y,
    input  logic signed [VEL_WIDTH-1:0]   turn_rate,
    input  logic signed [ANGLE_WIDTH-1:0] heading,
    input  logic                          field_frame,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic signed [VEL_WIDTH-1:0]   q_vel_x,
    output logic signed [VEL_WIDTH-1:0]   q_vel_y,
    output logic signed [VEL_WIDTH-1:0]   q_turn,
    output cls_t                          q_cls
);

    logic [ACC_WIDTH-1:0]  ang;
    logic [ACC_WIDTH-1:0]  phi;
    logic [ACC_WIDTH-1:0]  wrap;
    cls_t                  cls_in;

    logic signed [VEL_WIDTH-1:0] vx_mem  [QUEUE_DEPTH];
    logic signed [VEL_WIDTH-1:0] vy_mem  [QUEUE_DEPTH];
    logic signed [VEL_WIDTH-1:0] vt_mem  [QUEUE_DEPTH];
    cls_t                        cls_mem [QUEUE_DEPTH];

    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QCNT_WIDTH-1:0] count_reg;
    logic                  push;
    logic                  pop;

    // Rotate by minus heading; fold angles beyond a quarter turn by negating the vector.
    always_comb
    begin
        ang           = {heading, {(ACC_WIDTH - ANGLE_WIDTH){1'b0}}};
        phi           = '0 - ang;
        wrap          = phi + QUARTER_TURN;
        cls_in.rotate = field_frame;
        cls_in.flip   = wrap[ACC_WIDTH-1];
        cls_in.angle  = wrap[ACC_WIDTH-1] ? (phi + HALF_TURN) : phi;
    end

    assign in_ready = (count_reg != QCNT_WIDTH'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    assign q_vel_x = vx_mem[rd_ptr_reg];
    assign q_vel_y = vy_mem[rd_ptr_reg];
    assign q_turn  = vt_mem[rd_ptr_reg];
    assign q_cls   = cls_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            vx_mem[wr_ptr_reg]  <= vel_x;
            vy_mem[wr_ptr_reg]  <= vel_y;
            vt_mem[wr_ptr_reg]  <= turn_rate;
            cls_mem[wr_ptr_reg] <= cls_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_WIDTH'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_WIDTH'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_WIDTH'(1);
                2'b01:   count_reg <= count_reg - QCNT_WIDTH'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hdl/vcs_back.sv
// Command engine: shift-add CORDIC rotation; smoothing filters and offset terms on one shared multiplier.
module vcs_back
    import vcs_pkg::*;
#(
    parameter int VEL_WIDTH = VEL_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic signed [VEL_WIDTH-1:0]  q_vel_x,
    input  logic signed [VEL_WIDTH-1:0]  q_vel_y,
    input  logic signed [VEL_WIDTH-1:0]  q_turn,
    input  cls_t                         q_cls,
    input  logic signed [CFG_WIDTH-1:0]  offset_x,
    input  logic signed [CFG_WIDTH-1:0]  offset_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [VEL_WIDTH-1:0]  cmd_x,
    output logic signed [VEL_WIDTH-1:0]  cmd_y,
    output logic signed [VEL_WIDTH-1:0]  cmd_turn
);

    localparam int AW = VEL_WIDTH + 9;
    localparam int PW = AW + COEF_WIDTH;
    localparam int SW = VEL_WIDTH + 8;
    localparam int XW = VEL_WIDTH + 18;

    localparam logic signed [PW-1:0] V_MAX = {{(PW - VEL_WIDTH + 1){1'b0}}, {(VEL_WIDTH - 1){1'b1}}};
    localparam logic signed [PW-1:0] V_MIN = ~V_MAX;
    localparam logic [STEP_WIDTH-1:0] LAST_ROT = STEP_WIDTH'(CORDIC_STEPS - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCALE = 6'b000010,
        ST_ROT   = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FILT  = 6'b010000,
        ST_OFFS  = 6'b100000
    } state_t;

    state_t                  state_reg;
    logic [STEP_WIDTH-1:0]   step_reg;
    logic                    out_valid_reg;
    logic signed [SW-1:0]    sx_reg;
    logic signed [SW-1:0]    sy_reg;
    logic signed [SW-1:0]    st_reg;

    logic signed [VEL_WIDTH-1:0] vx_reg;
    logic signed [VEL_WIDTH-1:0] vy_reg;
    logic signed [VEL_WIDTH-1:0] vt_reg;
    logic                        flip_reg;
    logic signed [XW-1:0]        x_reg;
    logic signed [XW-1:0]        y_reg;
    logic [ACC_WIDTH-1:0]        z_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [VEL_WIDTH-1:0] cx_reg;
    logic signed [VEL_WIDTH-1:0] cmd_x_reg;
    logic signed [VEL_WIDTH-1:0] cmd_y_reg;
    logic signed [VEL_WIDTH-1:0] cmd_turn_reg;

    logic signed [AW-1:0]         mul_a;
    logic signed [COEF_WIDTH-1:0] mul_b;
    logic signed [PW-1:0]         mul_p;
    logic signed [XW-1:0]         dx;
    logic signed [XW-1:0]         dy;
    logic [ACC_WIDTH-1:0]         atan_val;
    logic signed [XW-1:0]         x_round;
    logic signed [XW-1:0]         y_round;
    logic signed [PW:0]           cx_sum;
    logic signed [PW:0]           cy_sum;
    logic signed [PW-1:0]         cx_full;
    logic signed [PW-1:0]         cy_full;
    logic signed [PW-1:0]         ct_full;
    logic                         out_free;
    logic                         out_load;

    function automatic logic signed [VEL_WIDTH-1:0] sat_v(input logic signed [PW-1:0] v);
        logic signed [VEL_WIDTH-1:0] r;
        if (v > V_MAX)
            r = V_MAX[VEL_WIDTH-1:0];
        else if (v < V_MIN)
            r = V_MIN[VEL_WIDTH-1:0];
        else
            r = v[VEL_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic signed [SW-1:0] filt_next(input logic signed [SW-1:0] s,
                                                       input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = ((PW+1)'(s) <<< 16) + (PW+1)'(p) + (PW+1)'(32'sd32768);
        return t[SW+15:16];
    endfunction

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd_x     = cmd_x_reg;
    assign cmd_y     = cmd_y_reg;
    assign cmd_turn  = cmd_turn_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == ST_OFFS) && (step_reg == STEP_WIDTH'(2)) && out_free;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SCALE:
            begin
                mul_a = (step_reg == '0) ? AW'(vx_reg) : AW'(vy_reg);
                mul_b = flip_reg ? CORDIC_GAIN_NEG : CORDIC_GAIN;
            end
            ST_FILT:
            begin
                if (step_reg == STEP_WIDTH'(0))
                begin
                    mul_a = (AW'(vx_reg) <<< 8) - AW'(sx_reg);
                    mul_b = W_XY_NEW;
                end
                else if (step_reg == STEP_WIDTH'(1))
                begin
                    mul_a = (AW'(vy_reg) <<< 8) - AW'(sy_reg);
                    mul_b = W_XY_NEW;
                end
                else
                begin
                    mul_a = (AW'(vt_reg) <<< 8) - AW'(st_reg);
                    mul_b = W_TURN_NEW;
                end
            end
            ST_OFFS:
            begin
                mul_a = AW'(st_reg);
                mul_b = (step_reg == '0) ? COEF_WIDTH'(offset_y) : COEF_WIDTH'(offset_x);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = atan_entry(step_reg);
    assign x_round  = (x_reg + XW'(32'sd32768)) >>> 16;
    assign y_round  = (y_reg + XW'(32'sd32768)) >>> 16;

    assign cx_sum  = ((PW+1)'(sx_reg) <<< 12) + (PW+1)'(prod_reg) + (PW+1)'(32'sd524288);
    assign cy_sum  = ((PW+1)'(sy_reg) <<< 12) - (PW+1)'(prod_reg) + (PW+1)'(32'sd524288);
    assign cx_full = PW'(cx_sum >>> 20);
    assign cy_full = PW'(cy_sum >>> 20);
    assign ct_full = (PW'(st_reg) + PW'(32'sd128)) >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            st_reg        <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= q_cls.rotate ? ST_SCALE : ST_FILT;
                        step_reg  <= '0;
                    end
                end
                ST_SCALE:
                begin
                    if (step_reg == STEP_WIDTH'(2))
                    begin
                        state_reg <= ST_ROT;
                        step_reg  <= '0;
                    end
                    else
                        step_reg <= step_reg + STEP_WIDTH'(1);
                end
                ST_ROT:
                begin
                    if (step_reg == LAST_ROT)
                    begin
                        state_reg <= ST_ROUND;
                        step_reg  <= '0;
                    end
                    else
                        step_reg <= step_reg + STEP_WIDTH'(1);
                end
                ST_ROUND:
                begin
                    state_reg <= ST_FILT;
                    step_reg  <= '0;
                end
                ST_FILT:
                begin
                    if (step_reg == STEP_WIDTH'(1))
                        sx_reg <= filt_next(sx_reg, prod_reg);
                    if (step_reg == STEP_WIDTH'(2))
                        sy_reg <= filt_next(sy_reg, prod_reg);
                    if (step_reg == STEP_WIDTH'(3))
                    begin
                        st_reg    <= filt_next(st_reg, prod_reg);
                        state_reg <= ST_OFFS;
                        step_reg  <= '0;
                    end
                    else
                        step_reg <= step_reg + STEP_WIDTH'(1);
                end
                ST_OFFS:
                begin
                    if (step_reg == STEP_WIDTH'(2))
                    begin
                        if (out_free)
                        begin
                            state_reg <= ST_IDLE;
                            step_reg  <= '0;
                        end
                    end
                    else
                        step_reg <= step_reg + STEP_WIDTH'(1);
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    step_reg  <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    vx_reg   <= q_vel_x;
                    vy_reg   <= q_vel_y;
                    vt_reg   <= q_turn;
                    flip_reg <= q_cls.flip;
                    z_reg    <= q_cls.angle;
                end
            end
            ST_SCALE:
            begin
                if (step_reg == STEP_WIDTH'(1))
                    x_reg <= prod_reg[XW-1:0];
                if (step_reg == STEP_WIDTH'(2))
                    y_reg <= prod_reg[XW-1:0];
            end
            ST_ROT:
            begin
                if (!z_reg[ACC_WIDTH-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_val;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_val;
                end
            end
            ST_ROUND:
            begin
                vx_reg <= sat_v(PW'(x_round));
                vy_reg <= sat_v(PW'(y_round));
            end
            ST_OFFS:
            begin
                if (step_reg == STEP_WIDTH'(1))
                    cx_reg <= sat_v(cx_full);
                if (step_reg == STEP_WIDTH'(2) && out_free)
                begin
                    cmd_x_reg    <= cx_reg;
                    cmd_y_reg    <= sat_v(cy_full);
                    cmd_turn_reg <= sat_v(ct_full);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hdl/velocity_command_shaper.sv
// Top level of the velocity command shaper: stream ports, offset registers, front and back.
//
// Input stream s_axis carries one velocity request per transfer: tdata holds vel_x,
// vel_y, turn_rate and heading, tuser the field_frame flag. Output stream m_axis
// carries one command per request: cmd_x, cmd_y and cmd_turn in tdata, in request order.
// The cfg port writes the wheel offsets (index 0 along x, index 1 along y); the user must
// write them only while idle, which the block itself does not enforce. Requests enter a
// two-deep queue; the engine behind it takes one at a time and works on it with one
// shared multiplier; it takes a new request only once it is done with the last one.
// A robot-frame request goes through the smoothing filters and the offset terms; a
// field-frame request first passes through the gain prescale, 16 CORDIC iterations
// and a rounding step.
// Reset clears the queue, the filter states, the offsets and the output valid.
// When m_axis stalls, the finished command holds in the output register, the engine
// waits at its last step, and the queue keeps taking requests until it is full.
module velocity_command_shaper
    import vcs_pkg::*;
#(
    parameter  int VEL_WIDTH       = VEL_WIDTH_DEF,
    parameter  int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
    localparam int IN_TDATA_WIDTH  = ((3 * VEL_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_WIDTH = ((3 * VEL_WIDTH + 7) / 8) * 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_TDATA_WIDTH-1:0]   s_axis_tdata,   // vel_x, vel_y, turn_rate, heading
    input  logic [0:0]                  s_axis_tuser,   // field_frame
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0]  m_axis_tdata,   // cmd_x, cmd_y, cmd_turn
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]        cfg_wdata
);

    logic signed [CFG_WIDTH-1:0]   offset_x_reg;
    logic signed [CFG_WIDTH-1:0]   offset_y_reg;

    logic signed [VEL_WIDTH-1:0]   vel_x;
    logic signed [VEL_WIDTH-1:0]   vel_y;
    logic signed [VEL_WIDTH-1:0]   turn_rate;
    logic signed [ANGLE_WIDTH-1:0] heading;

    logic                          q_valid;
    logic                          q_ready;
    logic signed [VEL_WIDTH-1:0]   q_vel_x;
    logic signed [VEL_WIDTH-1:0]   q_vel_y;
    logic signed [VEL_WIDTH-1:0]   q_turn;
    cls_t                          q_cls;

    logic signed [VEL_WIDTH-1:0]   cmd_x;
    logic signed [VEL_WIDTH-1:0]   cmd_y;
    logic signed [VEL_WIDTH-1:0]   cmd_turn;

    assign vel_x     = s_axis_tdata[VEL_WIDTH-1:0];
    assign vel_y     = s_axis_tdata[2*VEL_WIDTH-1:VEL_WIDTH];
    assign turn_rate = s_axis_tdata[3*VEL_WIDTH-1:2*VEL_WIDTH];
    assign heading   = s_axis_tdata[3*VEL_WIDTH+ANGLE_WIDTH-1:3*VEL_WIDTH];

    assign m_axis_tdata = OUT_TDATA_WIDTH'({cmd_turn, cmd_y, cmd_x});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_X: offset_x_reg <= cfg_wdata;
                CFG_OFFSET_Y: offset_y_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    vcs_front #(
        .VEL_WIDTH   (VEL_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .turn_rate   (turn_rate),
        .heading     (heading),
        .field_frame (s_axis_tuser[0]),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_vel_x     (q_vel_x),
        .q_vel_y     (q_vel_y),
        .q_turn      (q_turn),
        .q_cls       (q_cls)
    );

    vcs_back #(
        .VEL_WIDTH (VEL_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_vel_x   (q_vel_x),
        .q_vel_y   (q_vel_y),
        .q_turn    (q_turn),
        .q_cls     (q_cls),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd_x     (cmd_x),
        .cmd_y     (cmd_y),
        .cmd_turn  (cmd_turn)
    );

endmodule

FILE: hdl/vcs_checker.sv
// Port-level checks of the velocity command shaper and their bind.
module vcs_checker
    import vcs_pkg::*;
#(
    parameter  int VEL_WIDTH       = VEL_WIDTH_DEF,
    localparam int OUT_TDATA_WIDTH = ((3 * VEL_WIDTH + 7) / 8) * 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [OUT_TDATA_WIDTH-1:0]  m_axis_tdata
);

    logic [2:0] pending_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_fire && !out_fire)
            pending_reg <= pending_reg + 3'd1;
        else if (out_fire && !in_fire)
            pending_reg <= pending_reg - 3'd1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled command changed or dropped");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("command without a pending request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more requests in flight than queue and engine hold");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 |=> !m_axis_tvalid)
        else $error("command appeared one cycle after an empty block");

endmodule

bind velocity_command_shaper vcs_checker #(
    .VEL_WIDTH (VEL_WIDTH)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
